### design/des_ks_pkg.sv
// Package with the DES key schedule tables, types and permutation functions.
`timescale 1ns / 1ps
`default_nettype none

package des_ks_pkg;

    localparam int unsigned KeyBits   = 64;
    localparam int unsigned HalfBits  = 28;
    localparam int unsigned CdBits    = 56;
    localparam int unsigned SubBits   = 48;
    localparam int unsigned Rounds    = 16;
    localparam int unsigned RoundBits = 4;

    localparam logic [RoundBits-1:0] LAST_ROUND = 4'd15;

    typedef logic [KeyBits-1:0]   key_t;
    typedef logic [CdBits-1:0]    cd_t;
    typedef logic [HalfBits-1:0]  half_t;
    typedef logic [SubBits-1:0]   subkey_t;
    typedef logic [RoundBits-1:0] round_t;

    // Result of one round: the rotated C:D value and its subkey.
    typedef struct packed {
        cd_t     cd;
        subkey_t subkey;
    } round_out_t;

    // First permuted choice; table positions count from the most significant key bit.
    localparam int unsigned PC1_TAB [CdBits] = '{
        57, 49, 41, 33, 25, 17,  9,
         1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27,
        19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
         7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29,
        21, 13,  5, 28, 20, 12,  4
    };

    // Second permuted choice; table positions count from the most significant bit of C:D.
    localparam int unsigned PC2_TAB [SubBits] = '{
        14, 17, 11, 24,  1,  5,
         3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8,
        16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    // Set where the round rotates both halves by two places, else by one.
    localparam logic ROT_TWO [Rounds] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
    };

    function automatic cd_t pc1(input key_t key);
        cd_t res;
        for (int i = 0; i < CdBits; i++)
        begin
            res[CdBits-1-i] = key[KeyBits-PC1_TAB[i]];
        end
        return res;
    endfunction

    function automatic subkey_t pc2(input cd_t cd);
        subkey_t res;
        for (int i = 0; i < SubBits; i++)
        begin
            res[SubBits-1-i] = cd[CdBits-PC2_TAB[i]];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### design/des_ks_key_if.sv
// Channel interface that carries one DES key per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface des_ks_key_if;
    logic             valid;
    logic             ready;
    des_ks_pkg::key_t key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

`default_nettype wire

### design/des_ks_sub_if.sv
// Channel interface that carries one round subkey per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface des_ks_sub_if;
    logic                valid;
    logic                ready;
    des_ks_pkg::subkey_t subkey;
    des_ks_pkg::round_t  round;
    logic                last;

    modport source (output valid, output subkey, output round, output last, input ready);
    modport sink (input valid, input subkey, input round, input last, output ready);
endinterface

`default_nettype wire

### design/des_ks_round.sv
// One key schedule round: rotates both halves and applies the second permuted choice.
`timescale 1ns / 1ps
`default_nettype none

module des_ks_round (
    input  des_ks_pkg::cd_t        cd,
    input  des_ks_pkg::round_t     round,
    output des_ks_pkg::round_out_t result
);

    des_ks_pkg::half_t c_half;
    des_ks_pkg::half_t d_half;
    des_ks_pkg::half_t c_rot;
    des_ks_pkg::half_t d_rot;

    assign c_half = cd[des_ks_pkg::CdBits-1:des_ks_pkg::HalfBits];
    assign d_half = cd[des_ks_pkg::HalfBits-1:0];

    always_comb
    begin
        if (des_ks_pkg::ROT_TWO[round])
        begin
            c_rot = {c_half[des_ks_pkg::HalfBits-3:0], c_half[des_ks_pkg::HalfBits-1 -: 2]};
            d_rot = {d_half[des_ks_pkg::HalfBits-3:0], d_half[des_ks_pkg::HalfBits-1 -: 2]};
        end
        else
        begin
            c_rot = {c_half[des_ks_pkg::HalfBits-2:0], c_half[des_ks_pkg::HalfBits-1]};
            d_rot = {d_half[des_ks_pkg::HalfBits-2:0], d_half[des_ks_pkg::HalfBits-1]};
        end
    end

    assign result.cd     = {c_rot, d_rot};
    assign result.subkey = des_ks_pkg::pc2({c_rot, d_rot});

endmodule

`default_nettype wire

### design/des_key_schedule.sv
// Top level of the DES key schedule: one key in, sixteen round subkeys out.
`timescale 1ns / 1ps
`default_nettype none

// Each key transaction on key_stream yields sixteen subkey transactions on
// subkey_stream, in round order from the first round to the last, with last
// set only on the final round. An accepted key passes through the first
// permuted choice into the C:D state register; from then on one round is
// computed per cycle while subkey_stream is not stalled, by a single rotate
// and second permuted choice stage into the output register. The first
// subkey is computed from the C:D state register and enters the output
// register when the first round after the key's acceptance advances. The
// next key is taken in the same cycle that the final round of the current
// key moves into the output register, so with an always-ready sink the
// block sustains one subkey per cycle. A stall on subkey_stream holds the
// round state and the output register.
// There is no configuration and no state carried from one key to the next.

module des_key_schedule (
    input  wire logic    clk,
    input  wire logic    rst_n,
    des_ks_key_if.sink   key_stream,
    des_ks_sub_if.source subkey_stream
);

    // Round state for the key being expanded.
    des_ks_pkg::cd_t        cd_reg;
    des_ks_pkg::cd_t        cd_next;
    des_ks_pkg::round_t     round_reg;
    des_ks_pkg::round_t     round_next;
    logic                   busy_reg;
    logic                   busy_next;

    // Output register.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    des_ks_pkg::subkey_t    subkey_reg;
    des_ks_pkg::round_t     out_round_reg;
    logic                   last_reg;

    des_ks_pkg::round_out_t round_result;
    logic                   advance;
    logic                   final_round;
    logic                   key_accept;

    des_ks_round u_round (
        .cd     (cd_reg),
        .round  (round_reg),
        .result (round_result)
    );

    // While a key is being expanded, a round moves forward whenever the output register is free or drains.
    assign advance     = busy_reg && (!out_valid_reg || subkey_stream.ready);
    assign final_round = (round_reg == des_ks_pkg::LAST_ROUND);

    assign key_stream.ready = !busy_reg || (advance && final_round);
    assign key_accept       = key_stream.valid && key_stream.ready;

    always_comb
    begin
        cd_next    = cd_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        if (advance)
        begin
            cd_next    = round_result.cd;
            round_next = round_reg + 1'b1;
            if (final_round)
            begin
                busy_next = 1'b0;
            end
        end
        if (key_accept)
        begin
            cd_next    = des_ks_pkg::pc1(key_stream.key);
            round_next = '0;
            busy_next  = 1'b1;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (subkey_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            round_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            round_reg     <= round_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        cd_reg <= cd_next;
        if (advance)
        begin
            subkey_reg    <= round_result.subkey;
            out_round_reg <= round_reg;
            last_reg      <= final_round;
        end
    end

    assign subkey_stream.valid  = out_valid_reg;
    assign subkey_stream.subkey = subkey_reg;
    assign subkey_stream.round  = out_round_reg;
    assign subkey_stream.last   = last_reg;

endmodule

`default_nettype wire

### sim/des_key_schedule_tb.sv
// Self-checking testbench for the DES key schedule: keys in, sixteen round subkeys out.
`timescale 1ns / 1ps

// The testbench feeds DES keys into key_stream and checks every subkey
// transaction that leaves subkey_stream. An independent predictor applies
// the first permuted choice, rotates the two 28-bit halves by the DES shift
// schedule and applies the second permuted choice for each of the sixteen
// rounds. Its results go into a queue of expected subkeys, and each subkey
// transaction is compared field by field with the oldest entry.
//
// The stimulus starts with a directed set of keys: the all-zero and all-one
// patterns, the weak and semi-weak keys, keys that differ only in their
// parity bits, single set bits, and the standard test key. Random keys
// follow. Both sides insert random idle cycles, with calm stretches that
// have none. At least once the sender holds a key back until every
// expected subkey has arrived, so the block also starts from a drained
// state.

module des_key_schedule_tb;

    // Published DES tables. Positions count from the most significant bit of the source.
    localparam int unsigned PERM_CHOICE1 [56] = '{
        57, 49, 41, 33, 25, 17,  9,
         1, 58, 50, 42, 34, 26, 18,
        10,  2, 59, 51, 43, 35, 27,
        19, 11,  3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15,
         7, 62, 54, 46, 38, 30, 22,
        14,  6, 61, 53, 45, 37, 29,
        21, 13,  5, 28, 20, 12,  4
    };

    localparam int unsigned PERM_CHOICE2 [48] = '{
        14, 17, 11, 24,  1,  5,
         3, 28, 15,  6, 21, 10,
        23, 19, 12,  4, 26,  8,
        16,  7, 27, 20, 13,  2,
        41, 52, 31, 37, 47, 55,
        30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53,
        46, 42, 50, 36, 29, 32
    };

    // Left rotation applied to both halves before each round's subkey.
    localparam int unsigned SHIFT_SCHEDULE [16] = '{
        1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1
    };

    localparam int unsigned RANDOM_KEYS  = 109;
    // Idle cycles in a row after which the run is declared hung. The longest
    // legal quiet stretch is a sender gap or a sink stall plus the time a key
    // takes through the pipeline, so this is many times over.
    localparam int unsigned HANG_LIMIT   = 400;
    // Cycles to keep watching after the last expected subkey, so that a
    // stray extra transaction would still be caught.
    localparam int unsigned TAIL_CYCLES  = 40;

    typedef struct {
        des_ks_pkg::key_t key;
        int unsigned      gap;      // idle cycles before this key is offered
        bit               drain;    // hold this key until no subkey is owed
    } key_job_t;

    typedef struct {
        des_ks_pkg::subkey_t subkey;
        des_ks_pkg::round_t  round;
        logic                last;
    } subkey_rec_t;

    logic clk;
    logic rst_n;

    des_ks_key_if key_if ();
    des_ks_sub_if sub_if ();

    des_key_schedule u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_stream    (key_if),
        .subkey_stream (sub_if)
    );

    key_job_t    key_jobs [$];
    subkey_rec_t subkeys_owed [$];

    int unsigned key_total;
    int unsigned keys_taken;
    int unsigned error_count;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned idle_cycles;
    bit          sink_calm;

    // Computes the sixteen subkeys of one key and queues them in round order.
    function automatic void predict_subkeys(input des_ks_pkg::key_t k);
        des_ks_pkg::cd_t   cd;
        des_ks_pkg::cd_t   joined;
        des_ks_pkg::half_t c;
        des_ks_pkg::half_t d;
        subkey_rec_t       rec;
        for (int i = 0; i < 56; i++) begin
            cd[55-i] = k[64-PERM_CHOICE1[i]];
        end
        c = cd[55:28];
        d = cd[27:0];
        for (int r = 0; r < 16; r++) begin
            for (int s = 0; s < SHIFT_SCHEDULE[r]; s++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            joined = {c, d};
            for (int i = 0; i < 48; i++) begin
                rec.subkey[47-i] = joined[56-PERM_CHOICE2[i]];
            end
            rec.round = des_ks_pkg::round_t'(r);
            rec.last  = (r == 15);
            subkeys_owed.push_back(rec);
        end
    endfunction

    // Sink stall drawn per subkey; calm stretches stall not at all.
    function automatic int unsigned draw_stall();
        if ($urandom_range(0, 29) == 0)
        begin
            sink_calm = !sink_calm;
        end
        return sink_calm ? 0 : $urandom_range(0, 11);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        des_ks_pkg::key_t directed [$];
        key_job_t         job;
        bit               send_calm;
        rst_n         = 1'b0;
        key_if.valid  = 1'b0;
        key_if.key    = '0;
        sub_if.ready  = 1'b0;
        error_count   = 0;
        sink_calm     = 1'b0;
        send_calm     = 1'b0;

        // Weak, semi-weak and patterned keys, parity bits alone, the
        // extremes of the key field and the standard worked example.
        directed = '{
            64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
            64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE,
            64'h1F1F_1F1F_0E0E_0E0E, 64'hE0E0_E0E0_F1F1_F1F1,
            64'h01FE_01FE_01FE_01FE, 64'hFE01_FE01_FE01_FE01,
            64'h1FE0_1FE0_0EF1_0EF1, 64'hE01F_E01F_F10E_F10E,
            64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
            64'h0000_0000_0000_0002, 64'h4000_0000_0000_0000,
            64'h0000_0001_0000_0000, 64'h1334_5779_9BBC_DFF1,
            64'h0123_4567_89AB_CDEF
        };
        foreach (directed[i])
        begin
            job.key   = directed[i];
            job.gap   = (i % 3 == 0) ? 0 : $urandom_range(0, 11);
            // Start the standard test key from a fully drained block.
            job.drain = (i == 19);
            key_jobs.push_back(job);
        end
        for (int i = 0; i < RANDOM_KEYS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_calm = !send_calm;
            end
            job.key   = {$urandom, $urandom};
            job.gap   = send_calm ? 0 : $urandom_range(0, 11);
            job.drain = ($urandom_range(0, 24) == 0);
            key_jobs.push_back(job);
        end
        key_total = key_jobs.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sample on the falling edge so the clocked blocks have settled.
        while (keys_taken != key_total || subkeys_owed.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Key driver. A new key is offered only when the channel is free, after
    // the job's idle gap, and for drain jobs only once no key is on the
    // channel and nothing is owed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_if.valid <= 1'b0;
            key_if.key   <= '0;
            gap_left     <= 0;
        end
        else if (!key_if.valid || key_if.ready)
        begin
            if (key_jobs.size() != 0 && gap_left == 0 &&
                !(key_jobs[0].drain && (key_if.valid || subkeys_owed.size() != 0)))
            begin
                key_if.valid <= 1'b1;
                key_if.key   <= key_jobs[0].key;
                gap_left     <= (key_jobs.size() > 1) ? key_jobs[1].gap : 0;
                void'(key_jobs.pop_front());
            end
            else
            begin
                key_if.valid <= 1'b0;
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                end
            end
        end
    end

    // Monitor. Accepted keys feed the predictor; each accepted subkey is
    // checked against the oldest prediction. It also owns the sink's ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_if.ready <= 1'b0;
            stall_left   <= 0;
            keys_taken   <= 0;
        end
        else
        begin
            int unsigned next_stall;
            subkey_rec_t want;
            if (key_if.valid && key_if.ready)
            begin
                predict_subkeys(key_if.key);
                keys_taken <= keys_taken + 1;
            end

            if (sub_if.valid && sub_if.ready)
            begin
                if (subkeys_owed.size() == 0)
                begin
                    $error("unexpected subkey transaction: subkey %h round %0d last %0b",
                           sub_if.subkey, sub_if.round, sub_if.last);
                    error_count++;
                end
                else
                begin
                    want = subkeys_owed.pop_front();
                    if (sub_if.subkey !== want.subkey)
                    begin
                        $error("subkey: expected %h, got %h", want.subkey, sub_if.subkey);
                        error_count++;
                    end
                    if (sub_if.round !== want.round)
                    begin
                        $error("round: expected %0d, got %0d", want.round, sub_if.round);
                        error_count++;
                    end
                    if (sub_if.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, sub_if.last);
                        error_count++;
                    end
                end
                next_stall = draw_stall();
            end
            else
            begin
                next_stall = (stall_left != 0) ? stall_left - 1 : 0;
            end
            stall_left   <= next_stall;
            sub_if.ready <= (next_stall == 0);
        end
    end

    // Hang detection: too many cycles in a row without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((key_if.valid && key_if.ready) || (sub_if.valid && sub_if.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= HANG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

endmodule
